>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Simulation gets the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, ck, rs, ante, cons)

`define ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

>>> rtl/thps_pkg.sv
package thps_pkg;

  // Table and field geometry
  localparam int NUM_HARMONICS   = 16;
  localparam int IDX_W           = $clog2(NUM_HARMONICS);
  localparam int NUM_PHASES      = 3;
  localparam int ORDER_W         = 6;
  localparam int MAG_W           = 16;
  localparam int ANG_W           = 16;
  localparam int PT_W            = 8;
  localparam int OUT_W           = 32;

  // Period length is a power of two, so the phase wrap is a mask
  localparam int PPP_BITS          = 8;
  localparam int POINTS_PER_PERIOD = 1 << PPP_BITS;

  // Sine table: 2^SINE_TABLE_BITS points per turn, stored as one quarter wave
  localparam int SINE_TABLE_BITS = 10;
  localparam int QB              = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QB;
  localparam int SIN_W           = 15;

  // Scaling: gain * 927 / 2^31 with round half up
  localparam int GAIN_W      = 16;
  localparam int GAIN_RESET  = 100;
  localparam int GAIN_SCALE  = 927;
  localparam int GK_W        = GAIN_W + 10;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int ACC_W       = PROD_W + IDX_W;
  localparam int LO_W        = ACC_W / 2;
  localparam int HI_W        = ACC_W - LO_W;
  localparam int FRAC_SHIFT  = 31;
  localparam int SUM_W       = OUT_W + FRAC_SHIFT + 1;

  localparam logic [GK_W-1:0] GAIN_K_RESET = GK_W'(GAIN_RESET * GAIN_SCALE);

  // Opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_MUL,
    S_ADD,
    S_DONE
  } thps_state_t;

  // One harmonic table entry
  typedef struct packed {
    logic [ORDER_W-1:0]                order;
    logic [NUM_PHASES-1:0][MAG_W-1:0]  mag;
    logic [NUM_PHASES-1:0][ANG_W-1:0]  ofs;
  } thps_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    thps_entry_t       data;
  } thps_wr_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } thps_scale_ctl_t;

  // Taylor series divisors (2n)(2n+1)
  localparam longint unsigned TAYLOR_DIV [1:10] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
  localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;

  // Quarter-wave sample k, Q30 Taylor series rounded to Q15
  function automatic logic [SIN_W-1:0] quarter_sine(int unsigned k);
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    kk = 64'(k);
    x  = (kk * PI_Q48 + (64'd1 << (16 + SINE_TABLE_BITS))) >> (17 + SINE_TABLE_BITS);
    t  = x;
    s  = x;
    for (int n = 1; n <= 10; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n];
      if ((n % 2) == 1) begin
        s = (s >= t) ? s - t : 64'd0;
      end else begin
        s = s + t;
      end
    end
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SIN_W-1:0];
  endfunction

  typedef logic [SIN_W-1:0] qsine_tab_t [QUARTER];

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int k = 0; k < QUARTER; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  localparam qsine_tab_t      QSINE      = build_qsine();
  localparam logic [SIN_W-1:0] QSINE_PEAK = quarter_sine(QUARTER);

endpackage

>>> rtl/thps_table_ram.sv
module thps_table_ram (
  input  logic                    clk,
  input  logic                    rst,
  input  thps_pkg::thps_wr_t      wr,
  input  logic [thps_pkg::IDX_W-1:0] raddr,
  output thps_pkg::thps_entry_t   rdata
);
  import thps_pkg::*;

  thps_entry_t               mem [NUM_HARMONICS];
  logic [NUM_HARMONICS-1:0]  valid;
  thps_entry_t               mem_q;
  logic                      valid_q;

  // Mark written entries; reset empties the table at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    mem_q   <= mem[raddr];
    valid_q <= valid[raddr];
  end

  // Never-written entries read as zero
  assign rdata = valid_q ? mem_q : '0;

endmodule

>>> rtl/thps_sine_rom.sv
module thps_sine_rom (
  input  logic                                  clk,
  input  logic [thps_pkg::SINE_TABLE_BITS-1:0]  addr,
  output logic signed [thps_pkg::MAG_W-1:0]     value
);
  import thps_pkg::*;

  logic [1:0]        quad;
  logic [QB-1:0]     r;
  logic [QB:0]       k;
  logic [SIN_W-1:0]  mag;

  // Fold the address into the first quarter and look it up
  always_comb begin
    quad = addr[SINE_TABLE_BITS-1 -: 2];
    r    = addr[QB-1:0];
    k    = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    mag  = k[QB] ? QSINE_PEAK : QSINE[k[QB-1:0]];
  end

  // Apply the half-wave sign and register
  always_ff @(posedge clk) begin
    value <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

>>> rtl/thps_scaler.sv
module thps_scaler (
  input  logic                                clk,
  input  thps_pkg::thps_scale_ctl_t           ctl,
  input  logic signed [thps_pkg::ACC_W-1:0]   acc,
  input  logic [thps_pkg::GK_W-1:0]           gain_k,
  output logic signed [thps_pkg::OUT_W-1:0]   result
);
  import thps_pkg::*;

  localparam int PH_W = HI_W + GK_W + 1;
  localparam int R_W  = SUM_W - FRAC_SHIFT;
  localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (FRAC_SHIFT - 1);

  logic        [LO_W+GK_W-1:0] p_lo;
  logic signed [PH_W-1:0]      p_hi;
  logic signed [PH_W-1:0]      hi_s;
  logic signed [PH_W-1:0]      gk_s;
  logic signed [SUM_W-1:0]     sum;
  logic signed [R_W-1:0]       r;

  assign hi_s = PH_W'($signed(acc[ACC_W-1:LO_W]));
  assign gk_s = PH_W'($signed({1'b0, gain_k}));

  // Split the accumulator into two partial products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_lo <= (LO_W+GK_W)'(acc[LO_W-1:0]) * (LO_W+GK_W)'(gain_k);
      p_hi <= hi_s * gk_s;
    end
  end

  // Recombine and add the rounding half
  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      sum <= (SUM_W'(p_hi) <<< LO_W) + $signed(SUM_W'(p_lo)) + $signed(ROUND);
    end
  end

  // Drop the fraction and saturate to the output range
  always_comb begin
    r = sum[SUM_W-1:FRAC_SHIFT];
    if (r[R_W-1] != r[OUT_W-1]) begin
      result = r[R_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      result = r[OUT_W-1:0];
    end
  end

endmodule

>>> rtl/three_phase_harmonic_synthesizer.sv
// Three-phase harmonic synthesizer. A load word (opcode 0) writes one entry of a
// 16-entry harmonic table (order, and per phase a signed magnitude and a 16-bit phase
// offset). A compute word (opcode 1) walks the table through its registered-read RAM,
// one entry per cycle for all three phases, and sums magnitude * sin(order*(j+1)/256
// turn + offset) from a quarter-wave sine table; the sums are then scaled by
// output_gain * 927 / 2^31, rounded half up and saturated to 32 bits. A compute word
// occupies the block through the cycle in which it is taken, the table read loop, the
// drain of the RAM read and the lookup/multiply/accumulate pipeline, the scaler's split
// multiply and recombination, and the load of the output register. in_stall is
// high while a compute word is in work; a finished result sits in the output register,
// so the next word is taken while it waits, and a compute word holds in its last cycle
// until the previous result has left. The table is empty right after reset
// (per-entry valid bits, no clearing pass). output_gain is to be written through
// cfg_valid/cfg_ready only while the block is idle; the block itself does not
// enforce this.
module three_phase_harmonic_synthesizer (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [thps_pkg::IDX_W-1:0]          entry_index,
  input  logic [thps_pkg::ORDER_W-1:0]        harmonic_order,
  input  logic signed [thps_pkg::MAG_W-1:0]   magnitude_a,
  input  logic signed [thps_pkg::MAG_W-1:0]   magnitude_b,
  input  logic signed [thps_pkg::MAG_W-1:0]   magnitude_c,
  input  logic [thps_pkg::ANG_W-1:0]          offset_a,
  input  logic [thps_pkg::ANG_W-1:0]          offset_b,
  input  logic [thps_pkg::ANG_W-1:0]          offset_c,
  input  logic [thps_pkg::PT_W-1:0]           point_index,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [thps_pkg::OUT_W-1:0]   current_a,
  output logic signed [thps_pkg::OUT_W-1:0]   current_b,
  output logic signed [thps_pkg::OUT_W-1:0]   current_c,
  output logic [thps_pkg::PT_W-1:0]           sample_point,
  // gain register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [thps_pkg::GAIN_W-1:0]         output_gain
);
  import thps_pkg::*;

  `include "assert_macros.svh"

  thps_state_t       state, state_next;
  thps_scale_ctl_t   scale_ctl;
  thps_wr_t          wr;
  thps_entry_t       rd_entry;

  logic [IDX_W-1:0]  cnt;
  logic [PT_W-1:0]   point;
  logic [GK_W-1:0]   gain_k;
  logic              rd_v, p1_v, p2_v, p3_v;
  logic              in_take, take_load, take_compute, load_out;

  logic [PT_W:0]                  jp1;
  logic [ORDER_W+PT_W:0]          ord_prod;
  logic [PPP_BITS-1:0]            frac;
  logic [ANG_W-1:0]               base;
  logic [ANG_W-1:0]               ang   [NUM_PHASES];

  logic [SINE_TABLE_BITS-1:0]     p1_addr [NUM_PHASES];
  logic signed [MAG_W-1:0]        p1_mag  [NUM_PHASES];
  logic signed [MAG_W-1:0]        p2_mag  [NUM_PHASES];
  logic signed [MAG_W-1:0]        p2_sin  [NUM_PHASES];
  logic signed [PROD_W-1:0]       p3_prod [NUM_PHASES];
  logic signed [ACC_W-1:0]        acc     [NUM_PHASES];
  logic signed [OUT_W-1:0]        res     [NUM_PHASES];

  assign cfg_ready    = 1'b1;
  assign in_take      = in_valid && !in_stall;
  assign take_load    = in_take && (opcode == OP_LOAD);
  assign take_compute = in_take && (opcode == OP_COMPUTE);

  // Load words go straight into the table; the FSM keeps them away from a running walk
  always_comb begin
    wr.en       = take_load && (32'(entry_index) < NUM_HARMONICS);
    wr.addr     = entry_index;
    wr.data.order  = harmonic_order;
    wr.data.mag[0] = magnitude_a;
    wr.data.mag[1] = magnitude_b;
    wr.data.mag[2] = magnitude_c;
    wr.data.ofs[0] = offset_a;
    wr.data.ofs[1] = offset_b;
    wr.data.ofs[2] = offset_c;
  end

  thps_table_ram u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (cnt),
    .rdata (rd_entry)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    scale_ctl.mul_en = 1'b0;
    scale_ctl.add_en = 1'b0;
    load_out         = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (take_compute) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cnt == IDX_W'(NUM_HARMONICS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(rd_v || p1_v || p2_v || p3_v)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        scale_ctl.mul_en = 1'b1;
        state_next       = S_ADD;
      end
      S_ADD: begin
        scale_ctl.add_en = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Walk counter, pipeline valid chain, output valid, gain
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_v      <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      out_valid <= 1'b0;
      gain_k    <= GAIN_K_RESET;
    end else begin
      if (take_compute) begin
        cnt <= '0;
      end else if (state == S_RUN) begin
        cnt <= cnt + IDX_W'(1);
      end
      rd_v <= (state == S_RUN);
      p1_v <= rd_v;
      p2_v <= p1_v;
      p3_v <= p2_v;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        gain_k <= GK_W'(output_gain) * GK_W'(GAIN_SCALE);
      end
    end
  end

  // Hold the point of the word in work
  always_ff @(posedge clk) begin
    if (take_compute) begin
      point <= point_index;
    end
  end

  // Stage 1: harmonic angle per phase, wrapped to one period
  always_comb begin
    jp1      = {1'b0, point} + (PT_W+1)'(1);
    ord_prod = (ORDER_W+PT_W+1)'(rd_entry.order) * (ORDER_W+PT_W+1)'(jp1);
    frac     = ord_prod[PPP_BITS-1:0];
    base     = {frac, {(ANG_W-PPP_BITS){1'b0}}};
    for (int p = 0; p < NUM_PHASES; p++) begin
      ang[p] = base + rd_entry.ofs[p];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      p1_addr[p] <= ang[p][ANG_W-1 -: SINE_TABLE_BITS];
      p1_mag[p]  <= $signed(rd_entry.mag[p]);
      p2_mag[p]  <= p1_mag[p];
      p3_prod[p] <= p2_mag[p] * p2_sin[p];
    end
  end

  // Stage 2 sine lookup and per-phase scaling units
  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_phase
    thps_sine_rom u_sine (
      .clk   (clk),
      .addr  (p1_addr[g]),
      .value (p2_sin[g])
    );

    thps_scaler u_scale (
      .clk    (clk),
      .ctl    (scale_ctl),
      .acc    (acc[g]),
      .gain_k (gain_k),
      .result (res[g])
    );
  end

  // Stage 4: clear on a new point, accumulate each valid product
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (take_compute) begin
        acc[p] <= '0;
      end else if (p3_v) begin
        acc[p] <= acc[p] + ACC_W'(p3_prod[p]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      current_a    <= res[0];
      current_b    <= res[1];
      current_c    <= res[2];
      sample_point <= point;
    end
  end

  `ASSERT_IMPLIES(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == S_DONE)
  `ASSERT_IMPLIES(a_acc_in_walk, clk, rst, p3_v, (state == S_RUN) || (state == S_DRAIN))
  `ASSERT_IMPLIES(a_pipe_empty_scale, clk, rst, state == S_MUL, !(rd_v || p1_v || p2_v || p3_v))
  `ASSERT_NEXT(a_load_stays_idle, clk, rst, take_load, state == S_IDLE)

endmodule

>>> verif/three_phase_harmonic_synthesizer_tb.sv
module three_phase_harmonic_synthesizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = 16;
  localparam int STEP_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int BURST_CYCLES = 300;
  localparam int PHASES       = 7;
  localparam int PHASE_WORDS  = 205;
  localparam longint unsigned PI_FIX = 64'h3243F6A8885A3;

  // One input word as the sender sees it
  typedef struct packed {
    logic             op;
    logic [3:0]       idx;
    logic [5:0]       order;
    logic [2:0][15:0] mag;
    logic [2:0][15:0] ofs;
    logic [7:0]       pt;
  } word_t;

  // One output sample word
  typedef struct packed {
    logic signed [31:0] cur_a;
    logic signed [31:0] cur_b;
    logic signed [31:0] cur_c;
    logic [7:0]         pt;
  } sample_t;

  typedef struct {
    word_t w;
    bit    zero_lit;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [3:0] entry_index;
  logic [5:0] harmonic_order;
  logic signed [15:0] magnitude_a, magnitude_b, magnitude_c;
  logic [15:0] offset_a, offset_b, offset_c;
  logic [7:0] point_index;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] current_a, current_b, current_c;
  logic [7:0] sample_point;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] output_gain;

  // Predictor state: harmonic table, gain and sine lookup
  logic [5:0]         harm_order [ENTRIES];
  logic signed [15:0] harm_mag [ENTRIES][3];
  logic [15:0]        harm_ofs [ENTRIES][3];
  logic [15:0]        gain_reg;
  int                 sine_lut [1024];

  sample_t   points_due [$];
  plan_row_t plan [$];

  int  hold_left = 0;
  bit  burst_on = 1'b0;
  bit  burst_req = 1'b0;
  bit  calm = 1'b0;
  int  errors = 0;
  int  loads_sent = 0;
  int  points_sent = 0;
  int  samples_checked = 0;

  three_phase_harmonic_synthesizer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .entry_index    (entry_index),
    .harmonic_order (harmonic_order),
    .magnitude_a    (magnitude_a),
    .magnitude_b    (magnitude_b),
    .magnitude_c    (magnitude_c),
    .offset_a       (offset_a),
    .offset_b       (offset_b),
    .offset_c       (offset_c),
    .point_index    (point_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .current_a      (current_a),
    .current_b      (current_b),
    .current_c      (current_c),
    .sample_point   (sample_point),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .output_gain    (output_gain)
  );

  always #10 clk = ~clk;

  // Quarter-wave sine in Q15 from a Q30 Taylor series
  function automatic int quarter_wave(int k);
    longint unsigned kk, x, t, s, v, div;
    kk = longint'(k);
    x  = (kk * PI_FIX + (64'd1 << 26)) >> 27;
    t  = x;
    s  = x;
    for (int n = 1; n <= 10; n++) begin
      div = longint'(2 * n * (2 * n + 1));
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / div;
      if (n % 2 == 1) begin
        s = (s >= t) ? s - t : 64'd0;
      end else begin
        s = s + t;
      end
    end
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  // Fill the full-turn lookup from the quarter wave by symmetry
  function automatic void build_sine_lut();
    int quad, r, v;
    for (int i = 0; i < 1024; i++) begin
      quad = i >> 8;
      r    = i & 255;
      v    = quarter_wave((quad & 1) ? 256 - r : r);
      sine_lut[i] = (quad & 2) ? -v : v;
    end
  endfunction

  function automatic void clear_table();
    for (int e = 0; e < ENTRIES; e++) begin
      harm_order[e] = '0;
      for (int p = 0; p < 3; p++) begin
        harm_mag[e][p] = '0;
        harm_ofs[e][p] = '0;
      end
    end
  endfunction

  function automatic void store_entry(word_t w);
    harm_order[w.idx] = w.order;
    for (int p = 0; p < 3; p++) begin
      harm_mag[w.idx][p] = w.mag[p];
      harm_ofs[w.idx][p] = w.ofs[p];
    end
  endfunction

  // Sum all harmonics at point pt, scale by gain*927/2^31, round half up, saturate
  function automatic sample_t synth_point(logic [7:0] pt);
    longint             acc [3];
    longint             scaled;
    logic [13:0]        turns;
    logic [15:0]        ang;
    logic signed [31:0] lim [3];
    sample_t            res;
    for (int p = 0; p < 3; p++) begin
      acc[p] = 0;
    end
    for (int e = 0; e < ENTRIES; e++) begin
      turns = harm_order[e] * (pt + 14'd1);
      for (int p = 0; p < 3; p++) begin
        ang = {turns[7:0], 8'h00} + harm_ofs[e][p];
        acc[p] += longint'(harm_mag[e][p]) * longint'(sine_lut[ang[15:6]]);
      end
    end
    for (int p = 0; p < 3; p++) begin
      scaled = (acc[p] * longint'(gain_reg) * 64'sd927 + 64'sd1073741824) >>> 31;
      if (scaled > 64'sd2147483647) begin
        scaled = 64'sd2147483647;
      end else if (scaled < -64'sd2147483648) begin
        scaled = -64'sd2147483648;
      end
      lim[p] = scaled[31:0];
    end
    res.cur_a = lim[0];
    res.cur_b = lim[1];
    res.cur_c = lim[2];
    res.pt    = pt;
    return res;
  endfunction

  // Directed plan entries
  function automatic void add_load(logic [3:0] idx, logic [5:0] order,
                                   logic [15:0] ma, logic [15:0] mb, logic [15:0] mc,
                                   logic [15:0] oa, logic [15:0] ob, logic [15:0] oc);
    plan_row_t row;
    row.w.op    = thps_pkg::OP_LOAD;
    row.w.idx   = idx;
    row.w.order = order;
    row.w.mag   = {mc, mb, ma};
    row.w.ofs   = {oc, ob, oa};
    row.w.pt    = 8'($urandom);
    row.zero_lit = 1'b0;
    plan.push_back(row);
  endfunction

  function automatic void add_point(logic [7:0] pt, bit zero_lit);
    plan_row_t row;
    row.w        = random_word();
    row.w.op     = thps_pkg::OP_COMPUTE;
    row.w.pt     = pt;
    row.zero_lit = zero_lit;
    plan.push_back(row);
  endfunction

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.op  = ($urandom_range(0, 9) < 4) ? thps_pkg::OP_LOAD : thps_pkg::OP_COMPUTE;
    w.idx = 4'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      w.order = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    end else begin
      w.order = 6'($urandom);
    end
    for (int p = 0; p < 3; p++) begin
      w.mag[p] = pick_mag();
      w.ofs[p] = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) begin
      w.pt = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end else begin
      w.pt = 8'($urandom);
    end
    return w;
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict
  task automatic send_word(input word_t w, input bit zero_lit);
    int      gap;
    sample_t expv;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode         = w.op;
    entry_index    = w.idx;
    harmonic_order = w.order;
    magnitude_a    = w.mag[0];
    magnitude_b    = w.mag[1];
    magnitude_c    = w.mag[2];
    offset_a       = w.ofs[0];
    offset_b       = w.ofs[1];
    offset_c       = w.ofs[2];
    point_index    = w.pt;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.op == thps_pkg::OP_LOAD) begin
      store_entry(w);
      loads_sent++;
    end else begin
      if (zero_lit) begin
        expv    = '0;
        expv.pt = w.pt;
      end else begin
        expv = synth_point(w.pt);
      end
      points_due.push_back(expv);
      points_sent++;
    end
    @(negedge clk);
  endtask

  // Write the gain once all results are out and the block has settled
  task automatic write_gain(input logic [15:0] g);
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    output_gain = g;
    cfg_valid   = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain_reg = g;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input longint expv, input longint got);
    if (expv != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, expv, got);
      errors++;
    end
  endtask

  // Drive the output stall: random hold per word, plus the long hold-off
  always @(negedge clk) begin
    out_stall = burst_on || (hold_left > 0);
    if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin : hold_off
    wait (burst_req);
    @(posedge clk);
    burst_on = 1'b1;
    repeat (BURST_CYCLES) @(posedge clk);
    burst_on = 1'b0;
  end

  // Compare each taken sample word against the oldest prediction
  always @(posedge clk) begin : sample_check
    sample_t expv;
    if (!rst && out_valid && !out_stall) begin
      if (points_due.size() == 0) begin
        $display("%0t: sample word with no point pending, sample_point %0d",
                 $time, sample_point);
        errors++;
      end else begin
        expv = points_due.pop_front();
        check_field("current_a", expv.cur_a, current_a);
        check_field("current_b", expv.cur_b, current_b);
        check_field("current_c", expv.cur_c, current_c);
        check_field("sample_point", expv.pt, sample_point);
        samples_checked++;
      end
      hold_left = calm ? 0 : $urandom_range(0, 11);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < STEP_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] phase_gain [PHASES];
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = thps_pkg::OP_LOAD;
    entry_index    = '0;
    harmonic_order = '0;
    magnitude_a    = '0;
    magnitude_b    = '0;
    magnitude_c    = '0;
    offset_a       = '0;
    offset_b       = '0;
    offset_c       = '0;
    point_index    = '0;
    cfg_valid      = 1'b0;
    output_gain    = '0;
    gain_reg       = 16'd100;
    build_sine_lut();
    clear_table();

    // Empty table right after reset, then extremes of every field
    add_point(8'd0, 1'b1);
    add_point(8'd255, 1'b1);
    add_load(4'd0, 6'd1, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'h4000, 16'hFFFF);
    add_point(8'd0, 1'b0);
    add_point(8'd255, 1'b0);
    add_point(8'd64, 1'b0);
    add_load(4'd15, 6'd63, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hC000);
    add_point(8'd127, 1'b0);
    add_point(8'd191, 1'b0);
    // Order zero: a constant term set by the offset alone
    add_load(4'd7, 6'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'hC000, 16'h0000);
    add_point(8'd0, 1'b0);
    add_load(4'd10, 6'd42, 16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA, 16'h5555, 16'h8001);
    add_load(4'd5, 6'd21, 16'hAAAA, 16'h5555, 16'hEDCC, 16'h5555, 16'hAAAA, 16'h7FFE);
    add_point(8'd170, 1'b0);
    add_point(8'd85, 1'b0);
    // Zero every entry used so far; the sum must drop back to zero
    add_load(4'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_load(4'd15, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_load(4'd7, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_load(4'd10, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_load(4'd5, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_point(8'd200, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed plan at the reset gain
    foreach (plan[i]) begin
      send_word(plan[i].w, plan[i].zero_lit);
    end
    in_valid = 1'b0;

    // Random phases, each under its own gain
    phase_gain = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), 16'h8000,
                   16'($urandom), 16'd100};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_gain(phase_gain[ph]);
      calm = (ph == 3);
      if (ph == 2) begin
        burst_req = 1'b1;
      end
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0);
      in_valid = 1'b0;
    end
    calm = 1'b0;

    // Drain outstanding samples, then let the block settle
    while (points_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d words (%0d table loads, %0d points), %0d samples checked",
             loads_sent + points_sent, loads_sent, points_sent, samples_checked);
    $display("summary: %0d gain settings incl. 0 and 65535, one %0d-cycle output hold-off",
             PHASES + 1, BURST_CYCLES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/thps_pkg.sv
rtl/thps_table_ram.sv
rtl/thps_sine_rom.sv
rtl/thps_scaler.sv
rtl/three_phase_harmonic_synthesizer.sv
verif/three_phase_harmonic_synthesizer_tb.sv
